FILE: hw/rtl/prd_pkg.sv
package prd_pkg;

  // field widths
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned COLUMN_W = 15;
  localparam int unsigned PLANE_W  = 2;
  localparam int unsigned PLIM_W   = 3;

  // count byte marking
  localparam logic [CODE_W-1:0] COUNT_MARK = 8'hC0;
  localparam logic [CODE_W-1:0] COUNT_BITS = 8'h3F;

  // plane count clamp
  localparam logic [PLIM_W-1:0] PLANES_MIN = 3'd1;
  localparam logic [PLIM_W-1:0] PLANES_MAX = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PLANE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT     = 1'b1;
  localparam int unsigned CFG_DATA_W = 15;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one expansion command: a byte and how often it is repeated
  typedef struct packed {
    logic [CODE_W-1:0]  value;
    logic [COUNT_W-1:0] repeat_count;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

FILE: hw/rtl/pcx_rle_decoder_top.sv
// Run-length decoder for compressed raster rows. Each input word carries one code byte; a
// count byte (top two bits set) is absorbed by the front end and gives no output,
// a literal gives one output word and a run gives as many words as its count. The back end
// emits one word per cycle unless the receiver holds it back; a two-entry command queue lets
// the front end take further bytes while a run is expanding, and the input stalls only when
// the queue is full. Output words carry plane and column positions that wrap at the configured
// bytes per plane and plane count and run on across row boundaries. Configuration writes are
// taken at any time but are only meant to be made while the block is idle.
module pcx_rle_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] code_byte
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // [7:0] data_byte, [9:8] plane_index,
                                                    // [24:10] column_index, rest zero
  output logic                           m_tuser,   // [0] row_end
  output logic                           m_tlast    // run_end
);

  logic [prd_pkg::COLUMN_W-1:0] bytes_per_plane;
  logic [prd_pkg::PLIM_W-1:0]   plane_count;
  logic                         push;
  logic                         pop;
  prd_pkg::cmd_t                push_cmd;
  prd_pkg::cmd_t                head_cmd;
  prd_pkg::queue_status_t       qstat;
  logic [prd_pkg::CODE_W-1:0]   data_byte;
  logic [prd_pkg::PLANE_W-1:0]  plane_index;
  logic [prd_pkg::COLUMN_W-1:0] column_index;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_plane <= prd_pkg::COLUMN_W'(1);
      plane_count     <= prd_pkg::PLIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        prd_pkg::CFG_BYTES_PER_PLANE: bytes_per_plane <= cfg_wdata[prd_pkg::COLUMN_W-1:0];
        prd_pkg::CFG_PLANE_COUNT:     plane_count     <= cfg_wdata[prd_pkg::PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  prd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_code  (s_tdata),
    .qstat    (qstat),
    .in_ready (s_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  prd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  prd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .bytes_per_plane (bytes_per_plane),
    .plane_count     (plane_count),
    .qstat           (qstat),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .data_byte       (data_byte),
    .plane_index     (plane_index),
    .column_index    (column_index),
    .row_end         (m_tuser),
    .run_end         (m_tlast)
  );

  // pack output fields
  assign m_tdata = {7'd0, column_index, plane_index, data_byte};

endmodule

FILE: hw/rtl/prd_front.sv
module prd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [prd_pkg::CODE_W-1:0] in_code,
  input  prd_pkg::queue_status_t     qstat,
  output logic                       in_ready,
  output logic                       push,
  output prd_pkg::cmd_t              push_cmd
);

  logic                        awaiting_run_data;
  logic [prd_pkg::COUNT_W-1:0] run_length;
  logic                        is_count;
  logic                        take;

  // classify the incoming byte
  assign is_count = (in_code & prd_pkg::COUNT_MARK) == prd_pkg::COUNT_MARK;
  assign in_ready = !qstat.full;
  assign take     = in_valid && in_ready;

  // data after a count byte repeats; a zero count swallows it; a literal goes once
  always_comb begin
    push_cmd.value = in_code;
    if (awaiting_run_data) begin
      push_cmd.repeat_count = run_length;
      push                  = take && (run_length != '0);
    end else begin
      push_cmd.repeat_count = prd_pkg::COUNT_W'(1);
      push                  = take && !is_count;
    end
  end

  // count byte state
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_run_data <= 1'b0;
      run_length        <= '0;
    end else if (take) begin
      if (awaiting_run_data) begin
        awaiting_run_data <= 1'b0;
        run_length        <= '0;
      end else if (is_count) begin
        awaiting_run_data <= 1'b1;
        run_length        <= prd_pkg::COUNT_W'(in_code & prd_pkg::COUNT_BITS);
      end
    end
  end

endmodule

FILE: hw/rtl/prd_queue.sv
module prd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  prd_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output prd_pkg::cmd_t          head_cmd,
  output prd_pkg::queue_status_t qstat
);

  prd_pkg::cmd_t              slots [prd_pkg::QUEUE_DEPTH];
  logic [prd_pkg::QPTR_W-1:0] wr_ptr;
  logic [prd_pkg::QPTR_W-1:0] rd_ptr;
  logic [prd_pkg::QCNT_W-1:0] fill;
  logic                       do_push;
  logic                       do_pop;

  assign qstat.full      = fill == prd_pkg::QCNT_W'(prd_pkg::QUEUE_DEPTH);
  assign qstat.not_empty = fill != '0;
  assign do_push         = push && !qstat.full;
  assign do_pop          = pop && qstat.not_empty;
  assign head_cmd        = slots[rd_ptr];

  // pointer advance with wrap at depth
  function automatic logic [prd_pkg::QPTR_W-1:0] ptr_inc(input logic [prd_pkg::QPTR_W-1:0] p);
    if (p == prd_pkg::QPTR_W'(prd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + prd_pkg::QPTR_W'(1);
  endfunction

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + prd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - prd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/prd_back.sv
module prd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [prd_pkg::COLUMN_W-1:0] bytes_per_plane,
  input  logic [prd_pkg::PLIM_W-1:0]   plane_count,
  input  prd_pkg::queue_status_t       qstat,
  input  prd_pkg::cmd_t                head_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prd_pkg::CODE_W-1:0]   data_byte,
  output logic [prd_pkg::PLANE_W-1:0]  plane_index,
  output logic [prd_pkg::COLUMN_W-1:0] column_index,
  output logic                         row_end,
  output logic                         run_end
);

  logic                          busy;
  logic [prd_pkg::CODE_W-1:0]    cur_value;
  logic [prd_pkg::COUNT_W-1:0]   remaining;
  logic [prd_pkg::COLUMN_W-1:0]  column_count;
  logic [prd_pkg::PLANE_W-1:0]   plane_count_now;
  logic [prd_pkg::PLIM_W-1:0]    plane_limit;
  logic                          advance;
  logic                          last_of_run;
  logic                          line_done;
  logic                          planes_done;

  // clamp plane count to 1..4
  always_comb begin
    if (plane_count < prd_pkg::PLANES_MIN) begin
      plane_limit = prd_pkg::PLANES_MIN;
    end else if (plane_count > prd_pkg::PLANES_MAX) begin
      plane_limit = prd_pkg::PLANES_MAX;
    end else begin
      plane_limit = plane_count;
    end
  end

  // position wrap decisions
  assign line_done   = ({1'b0, column_count} + (prd_pkg::COLUMN_W + 1)'(1))
                       >= {1'b0, bytes_per_plane};
  assign planes_done = ({1'b0, plane_count_now} + prd_pkg::PLIM_W'(1)) >= plane_limit;

  // emit one word when the output register is free
  assign advance     = busy && (!out_valid || out_ready);
  assign last_of_run = remaining == prd_pkg::COUNT_W'(1);
  assign pop         = qstat.not_empty && (!busy || (advance && last_of_run));

  // run expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      remaining <= head_cmd.repeat_count;
    end else if (advance) begin
      remaining <= remaining - prd_pkg::COUNT_W'(1);
      if (last_of_run) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_value <= head_cmd.value;
    end
  end

  // column and plane counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      plane_count_now <= '0;
    end else if (advance) begin
      if (line_done) begin
        column_count <= '0;
        if (planes_done) begin
          plane_count_now <= '0;
        end else begin
          plane_count_now <= plane_count_now + prd_pkg::PLANE_W'(1);
        end
      end else begin
        column_count <= column_count + prd_pkg::COLUMN_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_byte    <= cur_value;
      plane_index  <= plane_count_now;
      column_index <= column_count;
      row_end      <= line_done && planes_done;
      run_end      <= last_of_run;
    end
  end

endmodule

FILE: sim/pcx_rle_decode_check.sv
module pcx_rle_decode_check
  import prd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [31:0]           m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  output int                    mismatch_count,
  output int                    bytes_due
);

  // one decoded byte with its position tags
  typedef struct {
    logic [7:0]          data;
    logic [PLANE_W-1:0]  plane;
    logic [COLUMN_W-1:0] column;
    logic                row_end;
    logic                run_end;
  } decoded_t;

  decoded_t expected_bytes[$];

  // register copies
  logic [COLUMN_W-1:0] line_bytes_cfg;
  logic [PLIM_W-1:0]   planes_cfg;

  // decoder state
  logic                in_run;
  logic [COUNT_W-1:0]  run_count;
  logic [COLUMN_W-1:0] column_now;
  logic [PLANE_W-1:0]  plane_now;

  // zero acts as one plane, anything over four as four
  function automatic logic [PLIM_W-1:0] active_planes();
    if (planes_cfg == 3'd0) return PLANES_MIN;
    if (planes_cfg > PLANES_MAX) return PLANES_MAX;
    return planes_cfg;
  endfunction

  // tag one output byte and advance column and plane
  task automatic tag_byte(input logic [7:0] value, input logic last);
    decoded_t d;
    logic line_done;
    logic row_done;
    line_done = (int'(column_now) + 1) >= int'(line_bytes_cfg);
    row_done  = line_done && ((int'(plane_now) + 1) >= int'(active_planes()));
    d.data    = value;
    d.plane   = plane_now;
    d.column  = column_now;
    d.row_end = row_done;
    d.run_end = last;
    expected_bytes.push_back(d);
    if (line_done) begin
      column_now = '0;
      plane_now  = row_done ? '0 : plane_now + 2'd1;
    end else begin
      column_now = column_now + 15'd1;
    end
  endtask

  // decode one compressed byte into its expected output words
  task automatic expand_code(input logic [7:0] code);
    int n;
    if (in_run) begin
      in_run = 1'b0;
      for (n = 0; n < int'(run_count); n++)
        tag_byte(code, (n + 1) == int'(run_count));
      run_count = '0;
    end else if ((code & COUNT_MARK) == COUNT_MARK) begin
      run_count = code[COUNT_W-1:0];
      in_run    = 1'b1;
    end else begin
      tag_byte(code, 1'b1);
    end
  endtask

  // follow both streams and compare each output word with the oldest prediction
  always @(posedge clk) begin
    decoded_t want;
    decoded_t got;
    logic bad;
    if (rst) begin
      expected_bytes.delete();
      line_bytes_cfg = 15'd1;
      planes_cfg     = 3'd1;
      in_run         = 1'b0;
      run_count      = '0;
      column_now     = '0;
      plane_now      = '0;
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BYTES_PER_PLANE: line_bytes_cfg = cfg_wdata[COLUMN_W-1:0];
          CFG_PLANE_COUNT:     planes_cfg = cfg_wdata[PLIM_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expand_code(s_tdata);
      if (m_tvalid && m_tready) begin
        got.data    = m_tdata[7:0];
        got.plane   = m_tdata[9:8];
        got.column  = m_tdata[24:10];
        got.row_end = m_tuser;
        got.run_end = m_tlast;
        if (expected_bytes.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: word with nothing predicted: tdata %h tuser %b tlast %b",
                     $time, m_tdata, m_tuser, m_tlast);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          bad = got.data != want.data || got.plane != want.plane ||
                got.column != want.column || got.row_end != want.row_end ||
                got.run_end != want.run_end || m_tdata[31:25] != 7'd0;
          if (bad) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch: want data %h plane %0d col %0d row_end %b run_end %b",
                       $time, want.data, want.plane, want.column, want.row_end,
                       want.run_end);
              $display("%0t:           got data %h plane %0d col %0d row_end %b run_end %b pad %h",
                       $time, got.data, got.plane, got.column, got.row_end,
                       got.run_end, m_tdata[31:25]);
            end
            mismatch_count++;
          end
        end
      end
    end
    bytes_due = expected_bytes.size();
  end

endmodule

FILE: sim/tb_pcx_rle_decoder_top.sv
module tb_pcx_rle_decoder_top;
  import prd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BYTES_PER_PLANE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // both sides stop idling while set
  logic quiet = 1'b0;
  int   mismatch_count;
  int   bytes_due;
  int   idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pcx_rle_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  pcx_rle_decode_check check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .bytes_due      (bytes_due)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 23);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // offer one code byte, with random gaps ahead of it
  task automatic send_code(input logic [7:0] code);
    while (!quiet && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the input until every predicted word is out, then let a zero run settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly literals and count/data pairs, some raw noise bytes
  task automatic send_random_items(input int count);
    int sent;
    int pick;
    int count_len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_code(8'($urandom_range(0, 191)));
        sent++;
      end else if (pick < 88) begin
        count_len = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
        send_code(COUNT_MARK | count_len[7:0]);
        send_code(8'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        send_code(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0]  opening [0:14];
    int unsigned phase_bytes [0:7];
    int unsigned phase_planes [0:7];
    int p;
    // literals at the edges, zero count, count after count, longest run
    opening = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'h40, 8'hC0, 8'h55, 8'hC1,
                8'hFF, 8'hFF, 8'hAA, 8'hC3, 8'hC0, 8'hC2, 8'h3C};
    phase_bytes  = '{1, 0, 2, 7, 5, 1, 16, 3};
    phase_planes = '{1, 0, 5, 3, 4, 7, 2, 4};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening
    write_reg(CFG_BYTES_PER_PLANE, 3);
    write_reg(CFG_PLANE_COUNT, 2);
    foreach (opening[i]) send_code(opening[i]);

    // random phases across register settings
    for (p = 0; p < 8; p++) begin
      write_reg(CFG_BYTES_PER_PLANE, phase_bytes[p]);
      write_reg(CFG_PLANE_COUNT, phase_planes[p]);
      quiet = (p == 3);
      send_random_items(48);
    end
    quiet = 1'b0;

    // widest line: long runs back to back at the top bytes per plane
    write_reg(CFG_BYTES_PER_PLANE, 32767);
    write_reg(CFG_PLANE_COUNT, 4);
    quiet = 1'b1;
    for (p = 0; p < 30; p++) begin
      send_code(8'hFF);
      send_code(8'($urandom_range(0, 255)));
    end
    quiet = 1'b0;

    // shrink both limits with counters mid-row
    write_reg(CFG_BYTES_PER_PLANE, 3);
    write_reg(CFG_PLANE_COUNT, 1);
    send_random_items(24);

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && bytes_due == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/prd_pkg.sv
hw/rtl/prd_front.sv
hw/rtl/prd_queue.sv
hw/rtl/prd_back.sv
hw/rtl/pcx_rle_decoder_top.sv
sim/pcx_rle_decode_check.sv
sim/tb_pcx_rle_decoder_top.sv
